// File: rtl/core/vlgm_pkg.sv
package vlgm_pkg;

    // Gain classes at or above this count skip the device gain
    localparam int CLASS_COUNT   = 4;
    // Highest half-dB index that still reads the table
    localparam int TABLE_ENTRIES = 200;

    localparam int GAIN_ROM_SIZE = 200;
    localparam int ROM_AW        = $clog2(GAIN_ROM_SIZE);
    localparam int IDX_LIMIT     = (TABLE_ENTRIES < GAIN_ROM_SIZE) ? TABLE_ENTRIES
                                                                   : GAIN_ROM_SIZE;

    // Field and datapath widths
    localparam int GAIN_W    = 16;
    localparam int DB_W      = 8;
    localparam int CLASS_W   = 4;
    localparam int PROD_W    = GAIN_W + DB_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int IDX_SUM_W = SUM_W + 1;
    localparam int IDX_W     = IDX_SUM_W - 16;
    localparam int OUT_W     = 17;

    localparam logic [GAIN_W-1:0]    FULL_SCALE = 16'hFFFF;
    localparam logic [IDX_SUM_W-1:0] ROUND_HALF = 27'h0008000;
    localparam logic [OUT_W-1:0]     UNITY_GAIN = 17'h10000;

    localparam logic [DB_W-1:0] STREAM_ATTEN_RST = 8'd100;
    localparam logic [DB_W-1:0] DEVICE_ATTEN_RST = 8'd35;
    localparam logic [DB_W-1:0] CLASS_ATTEN_RST  = 8'd35;

    typedef enum logic [1:0] {
        CFG_STREAM_ATTEN = 2'd0,
        CFG_DEVICE_ATTEN = 2'd1,
        CFG_CLASS_ATTEN  = 2'd2
    } cfg_reg_t;

    // Linear gain for -0.5 dB down to -100 dB in 0.5 dB steps
    localparam logic [GAIN_W-1:0] GAIN_ROM [GAIN_ROM_SIZE] = '{
        16'hf1ad, 16'he429, 16'hd765, 16'hcb59, 16'hbff9, 16'hb53b, 16'hab18, 16'ha186,
        16'h987d, 16'h8ff5, 16'h87e8, 16'h804d, 16'h7920, 16'h7259, 16'h6bf4, 16'h65ea,
        16'h6036, 16'h5ad5, 16'h55c0, 16'h50f4, 16'h4c6d, 16'h4826, 16'h441d, 16'h404d,
        16'h3cb5, 16'h394f, 16'h361a, 16'h3314, 16'h3038, 16'h2d86, 16'h2afa, 16'h2892,
        16'h264d, 16'h2429, 16'h2223, 16'h203a, 16'h1e6c, 16'h1cb9, 16'h1b1d, 16'h1999,
        16'h182a, 16'h16d0, 16'h158a, 16'h1455, 16'h1332, 16'h121f, 16'h111c, 16'h1027,
        16'h0f3f, 16'h0e65, 16'h0d97, 16'h0cd4, 16'h0c1c, 16'h0b6f, 16'h0acb, 16'h0a31,
        16'h099f, 16'h0915, 16'h0893, 16'h0818, 16'h07a4, 16'h0737, 16'h06cf, 16'h066e,
        16'h0612, 16'h05bb, 16'h0569, 16'h051b, 16'h04d2, 16'h048d, 16'h044c, 16'h040e,
        16'h03d4, 16'h039d, 16'h0369, 16'h0339, 16'h030a, 16'h02df, 16'h02b6, 16'h028f,
        16'h026a, 16'h0248, 16'h0227, 16'h0208, 16'h01eb, 16'h01cf, 16'h01b6, 16'h019d,
        16'h0186, 16'h0170, 16'h015b, 16'h0148, 16'h0136, 16'h0124, 16'h0114, 16'h0104,
        16'h00f6, 16'h00e8, 16'h00db, 16'h00cf, 16'h00c3, 16'h00b8, 16'h00ae, 16'h00a4,
        16'h009b, 16'h0092, 16'h008a, 16'h0082, 16'h007b, 16'h0074, 16'h006e, 16'h0067,
        16'h0062, 16'h005c, 16'h0057, 16'h0052, 16'h004d, 16'h0049, 16'h0045, 16'h0041,
        16'h003d, 16'h003a, 16'h0037, 16'h0034, 16'h0031, 16'h002e, 16'h002b, 16'h0029,
        16'h0027, 16'h0024, 16'h0022, 16'h0020, 16'h001f, 16'h001d, 16'h001b, 16'h001a,
        16'h0018, 16'h0017, 16'h0015, 16'h0014, 16'h0013, 16'h0012, 16'h0011, 16'h0010,
        16'h000f, 16'h000e, 16'h000d, 16'h000d, 16'h000c, 16'h000b, 16'h000b, 16'h000a,
        16'h0009, 16'h0009, 16'h0008, 16'h0008, 16'h0007, 16'h0007, 16'h0006, 16'h0006,
        16'h0006, 16'h0005, 16'h0005, 16'h0005, 16'h0004, 16'h0004, 16'h0004, 16'h0004,
        16'h0003, 16'h0003, 16'h0003, 16'h0003, 16'h0003, 16'h0002, 16'h0002, 16'h0002,
        16'h0002, 16'h0002, 16'h0002, 16'h0002, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
        16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

endpackage

// File: rtl/core/volume_to_linear_gain_map.sv
// Volume to linear gain map. Each input item carries a stream gain pair, a device gain
// pair, a secondary gain limit, a gain class and a channel select; each produces exactly
// one unsigned 1.16 linear gain multiplier (0x10000 is unity, 0 is mute). The selected 16-bit
// halves become attenuations (0xFFFF - gain) scaled by the three dB-range registers,
// summed, doubled, rounded and turned into a half-dB index that reads a 200-entry gain
// table. A class at or above CLASS_COUNT ignores the device gain; any zero gain in use mutes.
// The datapath is a four-stage pipeline (select, multiply, sum, table lookup), so one
// item is accepted every cycle when the output is not stalled, and each result passes
// through the stage registers in that order. Each stage holds its item while the next is
// full and stalled, and fills bubbles, so a stall loses nothing. Write the dB registers only
// while no items are in flight.
module volume_to_linear_gain_map
    import vlgm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write port
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [DB_W-1:0]  cfg_wdata,
    // input items
    input  logic             s_tvalid,
    output logic             s_tready,
    // [31:0] stream_gain_pair, [63:32] device_gain_pair, [79:64] secondary_limit
    input  logic [79:0]      s_tdata,
    // [3:0] secondary_class, [4] channel
    input  logic [4:0]       s_tuser,
    // result items
    output logic             m_tvalid,
    input  logic             m_tready,
    // [16:0] gain_multiplier, [23:17] zero
    output logic [23:0]      m_tdata
);

    // dB range registers
    logic [DB_W-1:0] stream_db_reg;
    logic [DB_W-1:0] device_db_reg;
    logic [DB_W-1:0] class_db_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_db_reg <= STREAM_ATTEN_RST;
            device_db_reg <= DEVICE_ATTEN_RST;
            class_db_reg  <= CLASS_ATTEN_RST;
        end else if (cfg_we) begin
            // drop writes to indexes past the register list
            unique case (cfg_addr)
                CFG_STREAM_ATTEN: stream_db_reg <= cfg_wdata;
                CFG_DEVICE_ATTEN: device_db_reg <= cfg_wdata;
                CFG_CLASS_ATTEN:  class_db_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage valids and advance chain: a stage takes a new item when it is empty
    // or its current item moves on in the same cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: pick halves, apply class bypass, form attenuations and mute flag
    logic [GAIN_W-1:0]  in_stream_pair_lo, in_stream_pair_hi;
    logic [GAIN_W-1:0]  in_dev_pair_lo, in_dev_pair_hi;
    logic [GAIN_W-1:0]  in_limit;
    logic [CLASS_W-1:0] in_class;
    logic               in_channel;
    logic [GAIN_W-1:0]  sg, dg;
    logic               bypass;

    assign in_stream_pair_lo = s_tdata[15:0];
    assign in_stream_pair_hi = s_tdata[31:16];
    assign in_dev_pair_lo    = s_tdata[47:32];
    assign in_dev_pair_hi    = s_tdata[63:48];
    assign in_limit          = s_tdata[79:64];
    assign in_class          = s_tuser[3:0];
    assign in_channel        = s_tuser[4];

    assign bypass = ({1'b0, in_class} >= (CLASS_W + 1)'(CLASS_COUNT));
    assign sg     = in_channel ? in_stream_pair_hi : in_stream_pair_lo;
    assign dg     = bypass ? FULL_SCALE : (in_channel ? in_dev_pair_hi : in_dev_pair_lo);

    logic [GAIN_W-1:0] s_att1_reg, d_att1_reg, l_att1_reg;
    logic              mute1_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s_att1_reg <= FULL_SCALE - sg;
            d_att1_reg <= FULL_SCALE - dg;
            l_att1_reg <= FULL_SCALE - in_limit;
            mute1_reg  <= (sg == '0) || (dg == '0) || (in_limit == '0);
        end
    end

    // Stage 2: scale each attenuation by its dB range
    logic [PROD_W-1:0] s_prod2_reg, d_prod2_reg, l_prod2_reg;
    logic              mute2_reg;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s_prod2_reg <= PROD_W'(s_att1_reg) * PROD_W'(stream_db_reg);
            d_prod2_reg <= PROD_W'(d_att1_reg) * PROD_W'(device_db_reg);
            l_prod2_reg <= PROD_W'(l_att1_reg) * PROD_W'(class_db_reg);
            mute2_reg   <= mute1_reg;
        end
    end

    // Stage 3: sum, double, round, and keep the half-dB index
    logic [SUM_W-1:0]     total;
    logic [IDX_SUM_W-1:0] idx_sum;
    logic [IDX_W-1:0]     idx3_reg;
    logic                 mute3_reg;

    assign total   = SUM_W'(s_prod2_reg) + SUM_W'(d_prod2_reg) + SUM_W'(l_prod2_reg);
    assign idx_sum = {total, 1'b0} + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (adv3) begin
            idx3_reg  <= idx_sum[IDX_SUM_W-1:16];
            mute3_reg <= mute2_reg;
        end
    end

    // Stage 4: table lookup and special cases
    logic [IDX_W-1:0]  rom_idx;
    logic [ROM_AW-1:0] rom_addr;
    logic [OUT_W-1:0]  gain_next;
    logic [OUT_W-1:0]  gain4_reg;

    assign rom_idx  = idx3_reg - IDX_W'(1);
    assign rom_addr = rom_idx[ROM_AW-1:0];

    always_comb begin
        priority if (mute3_reg) begin
            gain_next = '0;
        end else if (idx3_reg == '0) begin
            gain_next = UNITY_GAIN;
        end else if (idx3_reg > IDX_W'(IDX_LIMIT)) begin
            gain_next = '0;
        end else begin
            gain_next = OUT_W'(GAIN_ROM[rom_addr]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            gain4_reg <= gain_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'd0, gain4_reg};

endmodule
